/* rtl/sps_pkg.sv */
`timescale 1ns / 1ps
package sps_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned DiffW  = 9;
  localparam logic [WordW-1:0] NonceNone = 32'hFFFF_FFFF;
  localparam logic [DiffW-1:0] DiffReset = 9'd16;
  localparam logic [DiffW-1:0] DiffMax   = 9'd256;
  localparam logic [WordW-1:0] MsgBits   = 32'd64;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t w0;
    word_t w1;
  } sps_req_t;

  typedef struct packed {
    logic  done;
    word_t d0;
    word_t d1;
    word_t d2;
    word_t d3;
    word_t d4;
    word_t d5;
    word_t d6;
    word_t d7;
  } sps_rsp_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t bswap(input word_t x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

/* rtl/sps_if.sv */
`timescale 1ns / 1ps
interface sps_in_if import sps_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t challenge;
  modport source (output valid, output challenge, input ready);
  modport sink (input valid, input challenge, output ready);
endinterface

interface sps_out_if import sps_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t nonce;
  logic  found;
  modport source (output valid, output nonce, output found, input ready);
  modport sink (input valid, input nonce, input found, output ready);
endinterface

interface sps_cfg_if import sps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DiffW-1:0] difficulty_bits;
  modport source (output valid, output difficulty_bits, input ready);
  modport sink (input valid, input difficulty_bits, output ready);
endinterface

/* rtl/sps_round.sv */
`timescale 1ns / 1ps
module sps_round import sps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  sps_req_t req,
  output sps_rsp_t rsp
);

  // one compression round per cycle; schedule kept as a 16-word window
  word_t       w_r [16];
  word_t       w_nxt [16];
  word_t       a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [5:0]  t_r;
  logic        busy_r;
  logic        done_r;

  word_t s0, s1, wnew, bs1, ch, t1, bs0, mj, t2;

  always_comb begin
    s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    bs1  = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
    ch   = (e_r & f_r) ^ (~e_r & g_r);
    t1   = h_r + bs1 + ch + RoundK[t_r] + w_r[0];
    bs0  = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
    mj   = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2   = bs0 + mj;
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
    w_nxt[15] = wnew;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      t_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        t_r    <= '0;
        w_r[0]  <= req.w0;
        w_r[1]  <= req.w1;
        w_r[2]  <= 32'h8000_0000;
        for (int i = 3; i < 15; i++) w_r[i] <= '0;
        w_r[15] <= MsgBits;
        a_r <= InitH[0]; b_r <= InitH[1]; c_r <= InitH[2]; d_r <= InitH[3];
        e_r <= InitH[4]; f_r <= InitH[5]; g_r <= InitH[6]; h_r <= InitH[7];
      end else if (busy_r) begin
        w_r <= w_nxt;
        h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
        d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
        t_r <= t_r + 6'd1;
        if (t_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.d0 = InitH[0] + a_r;
  assign rsp.d1 = InitH[1] + b_r;
  assign rsp.d2 = InitH[2] + c_r;
  assign rsp.d3 = InitH[3] + d_r;
  assign rsp.d4 = InitH[4] + e_r;
  assign rsp.d5 = InitH[5] + f_r;
  assign rsp.d6 = InitH[6] + g_r;
  assign rsp.d7 = InitH[7] + h_r;

endmodule

/* rtl/sha256_pow_nonce_search_core.sv */
`timescale 1ns / 1ps
// Hashcash-style SHA-256 nonce search. Each challenge beat starts a search over
// nonces 0 upward; every nonce takes a load, 64 rounds of the single round unit,
// a digest capture and a leading-zero check, in that order. The input is not
// ready during a search; the result waits in an output register. Difficulty is
// written on the cfg channel; the user must write it only while idle, which the
// block does not enforce. Values above 256 act as 256; 0 returns nonce 0 at once.
module sha256_pow_nonce_search_core import sps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sps_in_if.sink   in_ch,
  sps_out_if.source out_ch,
  sps_cfg_if.sink  cfg_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HASH  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [DiffW-1:0] diff_r;
  word_t            chal_r;
  word_t            nonce_r;
  logic             found_r;
  sps_req_t         req;
  sps_rsp_t         rsp;
  logic [255:0]     dig_r;
  logic [DiffW-1:0] need;
  logic [255:0]     mask;
  logic             ok;
  logic             hash_go_r;

  sps_round u_round (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign need = (diff_r > DiffMax) ? DiffMax : diff_r;
  always_comb begin
    mask = '1;
    if (need != 9'd256) mask = ~({256{1'b1}} >> need[7:0]);
  end
  assign ok = ((dig_r & mask) == '0);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.nonce = nonce_r;
  assign out_ch.found = found_r;

  always_comb begin
    req.start = hash_go_r;
    req.w0    = bswap(chal_r);
    req.w1    = bswap(nonce_r);
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = (need == '0) ? ST_OUT : ST_HASH;
      ST_HASH:  if (rsp.done) state_nxt = ST_CHECK;
      ST_CHECK: if (ok || nonce_r == NonceNone - 32'd1) state_nxt = ST_OUT;
                else state_nxt = ST_HASH;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      diff_r    <= DiffReset;
      hash_go_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hash_go_r <= 1'b0;
      if (cfg_ch.valid) diff_r <= cfg_ch.difficulty_bits;
      if (state_r == ST_IDLE && in_ch.valid) begin
        chal_r    <= in_ch.challenge;
        nonce_r   <= '0;
        found_r   <= 1'b1;
        hash_go_r <= (need != '0);
      end
      if (state_r == ST_HASH && rsp.done)
        dig_r <= {rsp.d0, rsp.d1, rsp.d2, rsp.d3, rsp.d4, rsp.d5, rsp.d6, rsp.d7};
      if (state_r == ST_CHECK && !ok) begin
        nonce_r <= nonce_r + 32'd1;
        if (nonce_r == NonceNone - 32'd1) found_r <= 1'b0;
        else hash_go_r <= 1'b1;
      end
    end
  end

endmodule

/* rtl/sps_checker.sv */
`timescale 1ns / 1ps
module sps_checker import sps_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t out_nonce,
  input logic  out_found
);

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nonce))
    else $error("result dropped");

  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_nonce == NonceNone) else $error("bad miss nonce");

  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready) else $error("not idle after result");

endmodule

bind sha256_pow_nonce_search_core sps_checker u_sps_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_nonce(out_ch.nonce), .out_found(out_ch.found)
);

/* bench/tb_if_note.sv */
`timescale 1ns / 1ps
package tb_pow_pkg;
  import sps_pkg::*;

  typedef struct {
    word_t nonce;
    logic  found;
  } pow_result_t;

  function automatic word_t ror32(input word_t x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] digest_of(input word_t challenge, input word_t nonce);
    word_t w [64];
    word_t hv [8];
    word_t a, b, c, d, e, f, g, h, s0, s1, t1, t2;
    for (int t = 0; t < 64; t++) w[t] = '0;
    w[0]  = {challenge[7:0], challenge[15:8], challenge[23:16], challenge[31:24]};
    w[1]  = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
    w[2]  = 32'h8000_0000;
    w[15] = MsgBits;
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) hv[i] = InitH[i];
    {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
    for (int t = 0; t < 64; t++) begin
      s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + RoundK[t] + w[t];
      s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    digest_of = {hv[0] + a, hv[1] + b, hv[2] + c, hv[3] + d,
                 hv[4] + e, hv[5] + f, hv[6] + g, hv[7] + h};
  endfunction

  // first nonce whose digest has at least `difficulty` leading zero bits
  function automatic pow_result_t search_nonce(input word_t challenge,
                                               input logic [DiffW-1:0] difficulty);
    pow_result_t r;
    logic [DiffW-1:0] need;
    logic [255:0] dg;
    need = (difficulty > DiffMax) ? DiffMax : difficulty;
    r.nonce = NonceNone;
    r.found = 1'b0;
    for (word_t n = '0; n != NonceNone; n++) begin
      if (need == 0) begin
        r.nonce = n; r.found = 1'b1; return r;
      end
      dg = digest_of(challenge, n);
      if ((need == 256) ? (dg == '0) : ((dg >> (256 - need)) == '0)) begin
        r.nonce = n; r.found = 1'b1; return r;
      end
    end
    return r;
  endfunction
endpackage

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
  import sps_pkg::*;
  import tb_pow_pkg::*;

  localparam int unsigned CycleLimit = 8_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  sps_in_if  in_ch ();
  sps_out_if out_ch ();
  sps_cfg_if cfg_ch ();

  sha256_pow_nonce_search_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pow_result_t pending_results [$];
  logic [DiffW-1:0] difficulty_q = DiffReset;
  int unsigned fails = 0;
  int unsigned cycles = 0;
  logic no_idle = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.challenge = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.difficulty_bits = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("sha256_pow_nonce_search_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    pow_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: nonce %h found %b", $time, out_ch.nonce, out_ch.found);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.nonce !== want.nonce) begin
          $display("%0t nonce: expected %h actual %h", $time, want.nonce, out_ch.nonce);
          fails++;
        end
        if (out_ch.found !== want.found) begin
          $display("%0t found: expected %b actual %b", $time, want.found, out_ch.found);
          fails++;
        end
      end
    end
  end

  task automatic send_challenge(input word_t ch);
    in_ch.valid <= 1'b1;
    in_ch.challenge <= ch;
    do @(posedge clk); while (!in_ch.ready);
    pending_results = {pending_results, search_nonce(ch, difficulty_q)};
    if (!no_idle && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_difficulty(input logic [DiffW-1:0] d);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.difficulty_bits <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    difficulty_q = d;
    @(posedge clk);
  endtask

  task automatic test_zero_difficulty();
    set_difficulty('0);
    send_challenge('0);
    send_challenge(32'hFFFF_FFFF);
    send_challenge(32'hAAAA_5555);
    send_challenge(32'h5555_AAAA);
  endtask

  // saturating values written; a search at them would never end in a run
  task automatic test_high_settings();
    set_difficulty(DiffMax);
    set_difficulty(9'h1FF);
  endtask

  task automatic test_challenge_extremes();
    word_t pats [6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0123_4567,
                        32'hFEDC_BA98, 32'h7FFF_FFFE};
    for (int d = 1; d <= 8; d += 7) begin
      set_difficulty(d[DiffW-1:0]);
      foreach (pats[i]) send_challenge(pats[i]);
    end
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 9; p++) begin
      set_difficulty(DiffW'($urandom_range(0, 7)));
      no_idle = (p == 4);
      repeat (10) send_challenge($urandom);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_pause_until_empty();
    set_difficulty(DiffW'(3));
    repeat (3) send_challenge($urandom);
    drain();
    repeat (3) send_challenge($urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_difficulty();
    test_high_settings();
    test_challenge_extremes();
    test_pause_until_empty();
    test_random_phases();
    drain();
    repeat (100) @(posedge clk);
    if (fails == 0) $display("sha256_pow_nonce_search_core regression: pass");
    else $display("sha256_pow_nonce_search_core regression: fail");
    $finish;
  end
endmodule

/* sim.f */
rtl/sps_pkg.sv
rtl/sps_if.sv
rtl/sps_round.sv
rtl/sha256_pow_nonce_search_core.sv
rtl/sps_checker.sv
bench/tb_if_note.sv
bench/tb.sv
